// ===== hdl/tdr_pkg.sv =====
// Shared types and constants for the table-driven DFA recognizer.
// Used by tdr_ctrl, tdr_datapath and table_driven_dfa_recognizer; no dependencies.
`timescale 1ns / 1ps

package tdr_pkg;

    // Fixed field widths
    localparam int KIND_W   = 2;
    localparam int SLOT_W   = 4;
    localparam int ROW_W    = 4;
    localparam int CODE_W   = 8;
    localparam int STATE_W  = 5;
    localparam int MASK_W   = 16;
    localparam int VERD_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Default sizes of the automaton
    localparam int STATE_LIMIT_DEF  = 16;
    localparam int SYMBOL_LIMIT_DEF = 16;

    // Reset values of the configuration registers
    localparam logic [STATE_W-1:0] SYMBOL_COUNT_RST = 5'd1;
    localparam logic [STATE_W-1:0] START_STATE_RST  = 5'd1;
    localparam logic [MASK_W-1:0]  ACCEPT_MASK_RST  = 16'h0000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_STATE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_MASK  = 2'd2;

    // Verdict codes
    localparam logic [VERD_W-1:0] VERDICT_OK      = 2'd0;
    localparam logic [VERD_W-1:0] VERDICT_REJECT  = 2'd1;
    localparam logic [VERD_W-1:0] VERDICT_UNKNOWN = 2'd2;
    localparam logic [VERD_W-1:0] VERDICT_NOTRANS = 2'd3;

    // Input item kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE_SYMBOL = 2'd0,
        KIND_WRITE_TRANS  = 2'd1,
        KIND_CHAR         = 2'd2,
        KIND_END          = 2'd3
    } t_kind;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_FINISH
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic alpha_we;   // write alphabet slot from the input fields
        logic trans_we;   // write transition entry from the input fields
        logic look;       // character transfer: match symbol, launch table read
        logic step;       // apply the table read to the current state
        logic finish;     // load the verdict into the output register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_full;   // output register holds a result that is not leaving
    } t_status;

endpackage

// ===== hdl/tdr_ctrl.sv =====
// Controller FSM of the DFA recognizer: input handshake and datapath sequencing.
// Depends on tdr_pkg.
`timescale 1ns / 1ps

module tdr_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic [tdr_pkg::KIND_W-1:0]  i_in_kind,
    input  logic                        i_in_last,
    input  tdr_pkg::t_status            i_status,
    output logic                        o_in_stall,
    output tdr_pkg::t_cmd               o_cmd
);

    tdr_pkg::t_state r_state, n_state;
    logic            r_last, n_last;
    logic            accept;
    tdr_pkg::t_kind  kind;

    assign kind   = tdr_pkg::t_kind'(i_in_kind);
    assign accept = i_in_valid && (r_state == tdr_pkg::ST_IDLE);

    // State and latched end-of-string flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tdr_pkg::ST_IDLE;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_last  = r_last;
        unique case (r_state)
            tdr_pkg::ST_IDLE: begin
                if (accept) begin
                    n_last = i_in_last;
                    unique case (kind)
                        tdr_pkg::KIND_CHAR: n_state = tdr_pkg::ST_STEP;
                        tdr_pkg::KIND_END:  n_state = tdr_pkg::ST_FINISH;
                        default:            n_state = tdr_pkg::ST_IDLE;
                    endcase
                end
            end
            tdr_pkg::ST_STEP: begin
                n_state = r_last ? tdr_pkg::ST_FINISH : tdr_pkg::ST_IDLE;
            end
            tdr_pkg::ST_FINISH: begin
                // wait for room in the output register
                if (!i_status.out_full) begin
                    n_state = tdr_pkg::ST_IDLE;
                end
            end
            default: n_state = tdr_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_in_stall     = (r_state != tdr_pkg::ST_IDLE);
        o_cmd.alpha_we = accept && (kind == tdr_pkg::KIND_WRITE_SYMBOL);
        o_cmd.trans_we = accept && (kind == tdr_pkg::KIND_WRITE_TRANS);
        o_cmd.look     = accept && (kind == tdr_pkg::KIND_CHAR);
        o_cmd.step     = (r_state == tdr_pkg::ST_STEP);
        o_cmd.finish   = (r_state == tdr_pkg::ST_FINISH) && !i_status.out_full;
    end

endmodule

// ===== hdl/tdr_datapath.sv =====
// Datapath of the DFA recognizer: config registers, alphabet, transition RAM,
// current state, failure code and output register. Depends on tdr_pkg.
`timescale 1ns / 1ps

module tdr_datapath #(
    parameter int STATE_LIMIT  = tdr_pkg::STATE_LIMIT_DEF,
    parameter int SYMBOL_LIMIT = tdr_pkg::SYMBOL_LIMIT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tdr_pkg::t_cmd                  i_cmd,
    output tdr_pkg::t_status               o_status,
    // configuration writes
    input  logic                           i_cfg_we,
    input  logic [tdr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tdr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input item fields
    input  logic [tdr_pkg::SLOT_W-1:0]     i_slot,
    input  logic [tdr_pkg::ROW_W-1:0]      i_row,
    input  logic [tdr_pkg::CODE_W-1:0]     i_symbol_code,
    input  logic [tdr_pkg::STATE_W-1:0]    i_target_state,
    // result channel
    input  logic                           i_out_stall,
    output logic                           o_out_valid,
    output logic                           o_accepted,
    output logic [tdr_pkg::VERD_W-1:0]     o_verdict_code
);

    localparam int SYM_W  = (SYMBOL_LIMIT > 1) ? $clog2(SYMBOL_LIMIT) : 1;
    localparam int DEPTH  = STATE_LIMIT * SYMBOL_LIMIT;
    localparam int ADDR_W = $clog2(DEPTH);

    // Configuration registers
    logic [tdr_pkg::STATE_W-1:0] r_symbol_count;
    logic [tdr_pkg::STATE_W-1:0] r_start_state;
    logic [tdr_pkg::MASK_W-1:0]  r_accept_mask;

    // Stores
    logic [tdr_pkg::CODE_W-1:0]  r_alpha [SYMBOL_LIMIT];
    logic [tdr_pkg::STATE_W-1:0] r_trans [DEPTH];
    logic [tdr_pkg::STATE_W-1:0] r_rd_data;

    // String state
    logic [tdr_pkg::STATE_W-1:0] r_cur_state;
    logic [tdr_pkg::VERD_W-1:0]  r_fail;
    logic                        r_in_string;
    logic                        r_found;
    logic                        r_state_ok;

    // Output register
    logic                        r_out_valid;
    logic                        r_accepted;
    logic [tdr_pkg::VERD_W-1:0]  r_verdict;

    logic [SYMBOL_LIMIT-1:0]     hitv;
    logic [SYM_W-1:0]            hit_idx;
    logic                        found;
    logic [tdr_pkg::STATE_W-1:0] eff_state;
    logic [tdr_pkg::VERD_W-1:0]  eff_fail;
    logic [tdr_pkg::STATE_W-1:0] eff_row;
    logic                        state_ok;
    logic [ADDR_W-1:0]           rd_addr;
    logic [ADDR_W-1:0]           wr_addr;
    logic                        slot_ok;
    logic                        row_ok;
    logic [tdr_pkg::STATE_W-1:0] fin_state;
    logic                        fin_accepts;
    logic [tdr_pkg::VERD_W-1:0]  fin_verdict;
    logic [tdr_pkg::STATE_W-1:0] acc_idx;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_symbol_count <= tdr_pkg::SYMBOL_COUNT_RST;
            r_start_state  <= tdr_pkg::START_STATE_RST;
            r_accept_mask  <= tdr_pkg::ACCEPT_MASK_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tdr_pkg::CFG_SYMBOL_COUNT: r_symbol_count <= i_cfg_data[tdr_pkg::STATE_W-1:0];
                tdr_pkg::CFG_START_STATE:  r_start_state  <= i_cfg_data[tdr_pkg::STATE_W-1:0];
                tdr_pkg::CFG_ACCEPT_MASK:  r_accept_mask  <= i_cfg_data[tdr_pkg::MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // Range checks on load items
    assign slot_ok = (32'(i_slot) < SYMBOL_LIMIT);
    assign row_ok  = (32'(i_row) < STATE_LIMIT);
    assign wr_addr = ADDR_W'(32'(i_row) * SYMBOL_LIMIT + 32'(i_slot));

    // Alphabet slots
    always_ff @(posedge i_clk) begin
        if (i_cmd.alpha_we && slot_ok) begin
            r_alpha[SYM_W'(i_slot)] <= i_symbol_code;
        end
    end

    // Parallel symbol match, lowest active slot wins
    always_comb begin
        for (int i = 0; i < SYMBOL_LIMIT; i++) begin
            hitv[i] = (r_alpha[i] == i_symbol_code) && (i < 32'(r_symbol_count));
        end
    end

    always_comb begin
        hit_idx = '0;
        found   = 1'b0;
        for (int i = SYMBOL_LIMIT - 1; i >= 0; i--) begin
            if (hitv[i]) begin
                hit_idx = SYM_W'(i);
                found   = 1'b1;
            end
        end
    end

    // A new string starts from the start state with no failure
    assign eff_state = r_in_string ? r_cur_state : r_start_state;
    assign eff_fail  = r_in_string ? r_fail : tdr_pkg::VERDICT_OK;
    assign state_ok  = (eff_state != '0) && (32'(eff_state) <= STATE_LIMIT);
    assign eff_row   = eff_state - tdr_pkg::STATE_W'(1);
    assign rd_addr   = state_ok ? ADDR_W'(32'(eff_row) * SYMBOL_LIMIT + 32'(hit_idx))
                                : '0;

    // Transition table RAM: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.trans_we && slot_ok && row_ok) begin
            r_trans[wr_addr] <= i_target_state;
        end
        if (i_cmd.look) begin
            r_rd_data <= r_trans[rd_addr];
        end
    end

    // Verdict at end of string
    assign fin_state   = r_in_string ? r_cur_state : r_start_state;
    assign acc_idx     = fin_state - tdr_pkg::STATE_W'(1);
    assign fin_accepts = (fin_state != '0) && (fin_state <= tdr_pkg::STATE_W'(16))
                         && r_accept_mask[acc_idx[3:0]];
    always_comb begin
        if (r_in_string && (r_fail != tdr_pkg::VERDICT_OK)) begin
            fin_verdict = r_fail;
        end else if (fin_accepts) begin
            fin_verdict = tdr_pkg::VERDICT_OK;
        end else begin
            fin_verdict = tdr_pkg::VERDICT_REJECT;
        end
    end

    // String state: look latches match info, step applies the table read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_string <= 1'b0;
            r_fail      <= tdr_pkg::VERDICT_OK;
            r_cur_state <= tdr_pkg::START_STATE_RST;
            r_found     <= 1'b0;
            r_state_ok  <= 1'b0;
        end else if (i_cmd.look) begin
            r_in_string <= 1'b1;
            r_cur_state <= eff_state;
            r_fail      <= eff_fail;
            r_found     <= found;
            r_state_ok  <= state_ok;
        end else if (i_cmd.step) begin
            if (r_fail == tdr_pkg::VERDICT_OK) begin
                if (!r_found) begin
                    r_fail <= tdr_pkg::VERDICT_UNKNOWN;
                end else if (!r_state_ok || (r_rd_data == '0)) begin
                    r_fail <= tdr_pkg::VERDICT_NOTRANS;
                end else begin
                    r_cur_state <= r_rd_data;
                end
            end
        end else if (i_cmd.finish) begin
            r_in_string <= 1'b0;
            r_fail      <= tdr_pkg::VERDICT_OK;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_verdict  <= fin_verdict;
            r_accepted <= (fin_verdict == tdr_pkg::VERDICT_OK);
        end
    end

    assign o_status.out_full = r_out_valid && i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_accepted        = r_accepted;
    assign o_verdict_code    = r_verdict;

endmodule

// ===== hdl/table_driven_dfa_recognizer.sv =====
// Table-driven DFA string recognizer: top level joining controller and datapath.
// Depends on tdr_pkg, tdr_ctrl and tdr_datapath.
//
// Input channel (i_in_valid / o_in_stall) takes one item per transfer: alphabet
// loads, transition loads, characters, and end-of-string markers. Loads finish
// in the transfer cycle. For a character, the transfer cycle matches the byte
// against all alphabet slots and reads the transition RAM; the next cycle
// applies the read. A string end adds the FINISH state, which loads the
// verdict into the output register once that register has room. o_in_stall
// stays high until the item is done, so no new item is taken before then.
// Output channel (o_out_valid / i_out_stall) carries one verdict per string.
// The output register holds a verdict while the receiver stalls; input items
// keep flowing until a second verdict is due, which then waits for the first.
// Config port (i_cfg_valid / o_cfg_ready) is always ready; write it only when
// no string work is in flight. Synchronous active-low reset clears control
// state and config registers; alphabet and table contents must be loaded
// before use. No clearing pass is run after reset.
`timescale 1ns / 1ps

module table_driven_dfa_recognizer #(
    parameter int STATE_LIMIT  = tdr_pkg::STATE_LIMIT_DEF,
    parameter int SYMBOL_LIMIT = tdr_pkg::SYMBOL_LIMIT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input items
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [tdr_pkg::KIND_W-1:0]     i_in_kind,
    input  logic [tdr_pkg::SLOT_W-1:0]     i_in_slot,
    input  logic [tdr_pkg::ROW_W-1:0]      i_in_row,
    input  logic [tdr_pkg::CODE_W-1:0]     i_in_symbol_code,
    input  logic [tdr_pkg::STATE_W-1:0]    i_in_target_state,
    input  logic                           i_in_last,
    // results
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_out_accepted,
    output logic [tdr_pkg::VERD_W-1:0]     o_out_verdict_code,
    // configuration
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tdr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tdr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    tdr_pkg::t_cmd    cmd;
    tdr_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    tdr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_kind  (i_in_kind),
        .i_in_last  (i_in_last),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    tdr_datapath #(
        .STATE_LIMIT  (STATE_LIMIT),
        .SYMBOL_LIMIT (SYMBOL_LIMIT)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_slot         (i_in_slot),
        .i_row          (i_in_row),
        .i_symbol_code  (i_in_symbol_code),
        .i_target_state (i_in_target_state),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_accepted     (o_out_accepted),
        .o_verdict_code (o_out_verdict_code)
    );

endmodule

// ===== tb/table_driven_dfa_recognizer_test.sv =====
// Self-checking testbench for table_driven_dfa_recognizer: random and directed load,
// character and end-of-string transfers, checked against an in-bench DFA predictor.
// Depends on tdr_pkg and the RTL of table_driven_dfa_recognizer.
`timescale 1ns / 1ps

module table_driven_dfa_recognizer_test;

    localparam int NSTATES = tdr_pkg::STATE_LIMIT_DEF;
    localparam int NSYMS   = tdr_pkg::SYMBOL_LIMIT_DEF;

    typedef struct {
        tdr_pkg::t_kind                kind;
        logic [tdr_pkg::SLOT_W-1:0]    slot;
        logic [tdr_pkg::ROW_W-1:0]     row;
        logic [tdr_pkg::CODE_W-1:0]    code;
        logic [tdr_pkg::STATE_W-1:0]   target;
        logic                          last;
    } t_dfa_item;

    typedef struct {
        logic                          accepted;
        logic [tdr_pkg::VERD_W-1:0]    code;
    } t_verdict;

    // DUT connections
    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_in_valid = 1'b0;
    logic                              o_in_stall;
    logic [tdr_pkg::KIND_W-1:0]        i_in_kind = '0;
    logic [tdr_pkg::SLOT_W-1:0]        i_in_slot = '0;
    logic [tdr_pkg::ROW_W-1:0]         i_in_row = '0;
    logic [tdr_pkg::CODE_W-1:0]        i_in_symbol_code = '0;
    logic [tdr_pkg::STATE_W-1:0]       i_in_target_state = '0;
    logic                              i_in_last = 1'b0;
    logic                              o_out_valid;
    logic                              i_out_stall = 1'b0;
    logic                              o_out_accepted;
    logic [tdr_pkg::VERD_W-1:0]        o_out_verdict_code;
    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    logic [tdr_pkg::CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [tdr_pkg::CFG_DATA_W-1:0]    i_cfg_data = '0;

    table_driven_dfa_recognizer i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_in_kind          (i_in_kind),
        .i_in_slot          (i_in_slot),
        .i_in_row           (i_in_row),
        .i_in_symbol_code   (i_in_symbol_code),
        .i_in_target_state  (i_in_target_state),
        .i_in_last          (i_in_last),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_out_accepted     (o_out_accepted),
        .o_out_verdict_code (o_out_verdict_code),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Pending input items, expected verdicts, bookkeeping
    t_dfa_item  dfa_items_q[$];
    t_verdict   verdict_q[$];
    t_dfa_item  on_bus;
    int         items_unaccepted = 0;
    int         mismatch_count = 0;

    // Predictor state: automaton tables, registers, string progress
    logic [tdr_pkg::CODE_W-1:0]   alpha_mem [NSYMS];
    logic [tdr_pkg::STATE_W-1:0]  trans_mem [NSTATES*NSYMS];
    logic [tdr_pkg::STATE_W-1:0]  reg_symbol_count = tdr_pkg::SYMBOL_COUNT_RST;
    logic [tdr_pkg::STATE_W-1:0]  reg_start_state  = tdr_pkg::START_STATE_RST;
    logic [tdr_pkg::MASK_W-1:0]   reg_accept_mask  = tdr_pkg::ACCEPT_MASK_RST;
    logic [tdr_pkg::STATE_W-1:0]  dfa_state = tdr_pkg::START_STATE_RST;
    // VERDICT_OK doubles as "no failure"
    logic [tdr_pkg::VERD_W-1:0]   dfa_fail = tdr_pkg::VERDICT_OK;
    bit                           dfa_busy = 1'b0;

    // Stimulus-side copies, known when items are queued
    logic [tdr_pkg::CODE_W-1:0]   gen_alpha [NSYMS];
    int                           gen_count = 1;

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // End of string: judge the final state or report the first failure
    function automatic void close_string();
        logic [tdr_pkg::STATE_W-1:0] fin;
        logic [tdr_pkg::VERD_W-1:0]  v;
        t_verdict                    res;
        fin = dfa_busy ? dfa_state : reg_start_state;
        if (dfa_busy && dfa_fail != tdr_pkg::VERDICT_OK)
            v = dfa_fail;
        else if (fin >= 1 && fin <= 16 && reg_accept_mask[fin - 1])
            v = tdr_pkg::VERDICT_OK;
        else
            v = tdr_pkg::VERDICT_REJECT;
        res.accepted = (v == tdr_pkg::VERDICT_OK);
        res.code = v;
        verdict_q.push_back(res);
        dfa_state = reg_start_state;
        dfa_fail = tdr_pkg::VERDICT_OK;
        dfa_busy = 1'b0;
    endfunction

    // Advance the predicted automaton by one accepted item
    function automatic void dfa_step(input t_dfa_item it);
        int n;
        int hit;
        bit found;
        logic [tdr_pkg::STATE_W-1:0] nxt;
        case (it.kind)
            tdr_pkg::KIND_WRITE_SYMBOL: alpha_mem[it.slot] = it.code;
            tdr_pkg::KIND_WRITE_TRANS:  trans_mem[{it.row, it.slot}] = it.target;
            tdr_pkg::KIND_CHAR: begin
                if (!dfa_busy) begin
                    dfa_state = reg_start_state;
                    dfa_fail = tdr_pkg::VERDICT_OK;
                    dfa_busy = 1'b1;
                end
                if (dfa_fail == tdr_pkg::VERDICT_OK) begin
                    n = (int'(reg_symbol_count) < NSYMS) ? int'(reg_symbol_count) : NSYMS;
                    found = 1'b0;
                    hit = 0;
                    for (int i = 0; i < n; i++) begin
                        if (!found && alpha_mem[i] == it.code) begin
                            hit = i;
                            found = 1'b1;
                        end
                    end
                    if (!found) begin
                        dfa_fail = tdr_pkg::VERDICT_UNKNOWN;
                    end else if (dfa_state < 1 || dfa_state > NSTATES) begin
                        dfa_fail = tdr_pkg::VERDICT_NOTRANS;
                    end else begin
                        nxt = trans_mem[(int'(dfa_state) - 1) * NSYMS + hit];
                        if (nxt == 0)
                            dfa_fail = tdr_pkg::VERDICT_NOTRANS;
                        else
                            dfa_state = nxt;
                    end
                end
                if (it.last)
                    close_string();
            end
            default: close_string();
        endcase
    endfunction

    // Sender: bursts of random length separated by random gaps
    int burst_left = 1;
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                dfa_step(on_bus);
                items_unaccepted--;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left != 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (dfa_items_q.size() != 0) begin
                    on_bus = dfa_items_q.pop_front();
                    i_in_kind         <= on_bus.kind;
                    i_in_slot         <= on_bus.slot;
                    i_in_row          <= on_bus.row;
                    i_in_symbol_code  <= on_bus.code;
                    i_in_target_state <= on_bus.target;
                    i_in_last         <= on_bus.last;
                    i_in_valid        <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall pattern: free-running, random, or mostly stalled
    int stall_mode = 0;
    int stall_hold = 0;

    always @(posedge i_clk) begin
        if (stall_hold == 0) begin
            stall_hold = $urandom_range(20, 200);
            stall_mode = $urandom_range(0, 2);
        end else begin
            stall_hold--;
        end
        case (stall_mode)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= 1'($urandom_range(0, 1));
            default: i_out_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // Monitor: compare each verdict transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (verdict_q.size() == 0) begin
                report_mismatch($sformatf("verdict with none expected: acc=%0b code=%0d",
                                          o_out_accepted, o_out_verdict_code));
            end else begin
                want = verdict_q.pop_front();
                if (o_out_accepted !== want.accepted)
                    report_mismatch($sformatf("accepted %b, expected %b",
                                              o_out_accepted, want.accepted));
                if (o_out_verdict_code !== want.code)
                    report_mismatch($sformatf("verdict_code %0d, expected %0d",
                                              o_out_verdict_code, want.code));
            end
        end
    end

    // Queue one item; unused fields carry random values
    task automatic push_item(input tdr_pkg::t_kind kind, input int slot, input int row,
                             input int code, input int target, input bit last);
        t_dfa_item it;
        it.kind = kind;
        it.slot = tdr_pkg::SLOT_W'(slot);
        it.row = tdr_pkg::ROW_W'(row);
        it.code = tdr_pkg::CODE_W'(code);
        it.target = tdr_pkg::STATE_W'(target);
        it.last = last;
        if (kind == tdr_pkg::KIND_WRITE_SYMBOL)
            gen_alpha[slot] = tdr_pkg::CODE_W'(code);
        dfa_items_q.push_back(it);
        items_unaccepted++;
    endtask

    task automatic push_symbol(input int slot, input int code);
        push_item(tdr_pkg::KIND_WRITE_SYMBOL, slot, $urandom_range(0, 15), code,
                  $urandom_range(0, 16), 1'($urandom_range(0, 1)));
    endtask

    task automatic push_trans(input int row, input int slot, input int target);
        push_item(tdr_pkg::KIND_WRITE_TRANS, slot, row, $urandom_range(0, 255), target,
                  1'($urandom_range(0, 1)));
    endtask

    task automatic push_char(input int code, input bit last);
        push_item(tdr_pkg::KIND_CHAR, $urandom_range(0, 15), $urandom_range(0, 15), code,
                  $urandom_range(0, 16), last);
    endtask

    task automatic push_end();
        push_item(tdr_pkg::KIND_END, $urandom_range(0, 15), $urandom_range(0, 15),
                  $urandom_range(0, 255), $urandom_range(0, 16),
                  1'($urandom_range(0, 1)));
    endtask

    // Mostly bytes of the active alphabet, sometimes any byte at all
    function automatic int pick_char();
        if ($urandom_range(0, 99) < 90)
            return int'(gen_alpha[$urandom_range(0, gen_count - 1)]);
        return $urandom_range(0, 255);
    endfunction

    function automatic int pick_symbol_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return $urandom_range(0, 255);
            default: return $urandom_range(8'h40, 8'h4F);
        endcase
    endfunction

    function automatic int pick_target();
        return ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 16);
    endfunction

    // Wait until every item is taken and every verdict has arrived
    task automatic wait_drained();
        while (items_unaccepted != 0 || verdict_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write all three registers back to back; valid drops once at the end
    task automatic write_regs(input int count, input int start, input int mask);
        logic [tdr_pkg::CFG_IDX_W-1:0]  idx [3];
        logic [tdr_pkg::CFG_DATA_W-1:0] val [3];
        idx[0] = tdr_pkg::CFG_SYMBOL_COUNT;  val[0] = tdr_pkg::CFG_DATA_W'(count);
        idx[1] = tdr_pkg::CFG_START_STATE;   val[1] = tdr_pkg::CFG_DATA_W'(start);
        idx[2] = tdr_pkg::CFG_ACCEPT_MASK;   val[2] = tdr_pkg::CFG_DATA_W'(mask);
        i_cfg_valid <= 1'b1;
        for (int k = 0; k < 3; k++) begin
            i_cfg_index <= idx[k];
            i_cfg_data <= val[k];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            case (idx[k])
                tdr_pkg::CFG_SYMBOL_COUNT: reg_symbol_count = val[k][tdr_pkg::STATE_W-1:0];
                tdr_pkg::CFG_START_STATE: begin
                    reg_start_state = val[k][tdr_pkg::STATE_W-1:0];
                    if (!dfa_busy)
                        dfa_state = reg_start_state;
                end
                default: reg_accept_mask = val[k][tdr_pkg::MASK_W-1:0];
            endcase
        end
        i_cfg_valid <= 1'b0;
        gen_count = count;
    endtask

    // Stimulus sequence
    initial begin
        int cnt;
        int start;
        int mask;
        int queued;
        int len;
        bit use_last;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_regs(16, 1, 16'h8001);

        // Fill both stores so that no unwritten entry is ever read
        for (int s = 0; s < NSYMS; s++)
            push_symbol(s, (s == 0) ? 8'h00 : (s == NSYMS - 1) ? 8'hFF
                                             : $urandom_range(8'h40, 8'h4F));
        for (int r = 0; r < NSTATES; r++)
            for (int s = 0; s < NSYMS; s++)
                push_trans(r, s, pick_target());

        // Directed: empty string judged on the start state
        push_end();
        // duplicate byte in slots 2 and 5: the lower slot must win
        push_symbol(1, 8'h42);
        push_symbol(2, 8'h41);
        push_symbol(5, 8'h41);
        push_trans(0, 2, 16);
        push_trans(0, 5, 0);
        push_char(8'h41, 1'b1);
        // missing transition from the highest state
        push_trans(15, 0, 0);
        push_char(8'h41, 1'b0);
        push_char(8'h00, 1'b1);
        // unknown byte, then the rest of the string is ignored
        push_char(8'h3A, 1'b0);
        push_char(8'h41, 1'b0);
        push_end();
        // top alphabet slot into a non-accepting state
        push_trans(0, 15, 7);
        push_char(8'hFF, 1'b1);
        // table load in the middle of a string takes effect at once
        push_char(8'h41, 1'b0);
        push_trans(15, 2, 1);
        push_char(8'h41, 1'b1);
        // end marker after a character, then back-to-back empty strings
        push_char(8'h41, 1'b0);
        push_end();
        push_end();
        push_end();
        wait_drained();

        // Random phases, extreme register settings first
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin cnt = 16; start = 16; mask = 16'h0000; end
                1: begin cnt = 1;  start = 1;  mask = 16'hFFFF; end
                default: begin
                    cnt = $urandom_range(1, 16);
                    start = $urandom_range(1, 16);
                    mask = $urandom_range(0, 16'hFFFF);
                end
            endcase
            write_regs(cnt, start, mask);
            queued = 0;
            while (queued < 210) begin
                case ($urandom_range(0, 19))
                    0: begin
                        push_symbol($urandom_range(0, 15), pick_symbol_byte());
                        queued++;
                    end
                    1, 2: begin
                        push_trans($urandom_range(0, 15), $urandom_range(0, 15), pick_target());
                        queued++;
                    end
                    3: begin
                        push_end();
                        queued++;
                    end
                    default: begin
                        len = $urandom_range(1, 8);
                        use_last = ($urandom_range(0, 9) < 7);
                        for (int j = 0; j < len; j++) begin
                            if ($urandom_range(0, 19) == 0) begin
                                push_trans($urandom_range(0, 15), $urandom_range(0, 15),
                                           pick_target());
                                queued++;
                            end
                            push_char(pick_char(), use_last && (j == len - 1));
                            queued++;
                        end
                        if (!use_last) begin
                            push_end();
                            queued++;
                        end
                    end
                endcase
            end
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
